[hw/rtl/escape_sequence_decoder_core_assert.svh]
// ----------------------------------------------------------------------------
// Escape sequence decoder assertion macros
// Concurrent checks on clk, disabled while rst is high. Define NO_ASSERTIONS
// to compile them away.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_DECODER_CORE_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge outside reset
`define ESD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("escape decoder check failed");

// antecedent implies consequent in the next cycle
`define ESD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("escape decoder check failed");

`else

`define ESD_ASSERT_ALWAYS(label, cond)
`define ESD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hw/rtl/esd_pkg.sv]
// ----------------------------------------------------------------------------
// esd_pkg
// Types, codes and helpers of the escape sequence decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

  // input request kinds
  localparam logic [1:0] CMD_DATA     = 2'd0;
  localparam logic [1:0] CMD_BOUNDARY = 2'd1;
  localparam logic [1:0] CMD_END      = 2'd2;

  // configuration register indexes
  localparam logic CFG_INTERPRET = 1'b0;
  localparam logic CFG_SUPPRESS  = 1'b1;

  // character codes
  localparam logic [7:0] CHR_ESC     = 8'h1B;
  localparam logic [7:0] CHR_BSLASH  = 8'h5C;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_NEWLINE = 8'h0A;

  localparam logic [1:0] OCT_DIGITS = 2'd3;
  localparam logic [1:0] HEX_DIGITS = 2'd2;

  typedef enum logic [4:0] {
    MODE_NORMAL  = 5'b00001,
    MODE_BSLASH  = 5'b00010,
    MODE_OCTAL   = 5'b00100,
    MODE_HEX     = 5'b01000,
    MODE_STOPPED = 5'b10000
  } mode_t;

  // up to two result bytes produced by one request
  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
  } emit_t;

  function automatic emit_t emit_push(emit_t e, logic [7:0] b);
    emit_t r;
    r = e;
    if (e.n == 2'd0) begin
      r.b0 = b;
      r.n  = 2'd1;
    end else if (e.n == 2'd1) begin
      r.b1 = b;
      r.n  = 2'd2;
    end
    return r;
  endfunction

  // {valid, value} of a hex digit character
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, c[3:0]};
    end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/escape_sequence_decoder_core.sv]
// ----------------------------------------------------------------------------
// escape_sequence_decoder_core
// Streaming decoder for echo-style backslash escapes: letter, octal (\0nnn)
// and hex (\xHH) escapes, \c stop, a space per boundary, optional newline at the end.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   -------  ---------  -------------------  -----------------------------
//   in       input      in_valid / in_stall  cmd[1:0], ch[7:0]
//   out      output     out_valid/out_stall  out_byte[7:0], last
//   cfg      input      cfg_valid/cfg_ready  cfg_index[0:0], cfg_data[0:0]
//
// One request is decoded per cycle while in_stall is low, straight into a
// two-entry result register; a request giving one byte or none keeps
// 1 request/cycle while the output does not stall, a request giving two
// bytes stalls the input while the second byte drains from that register.
// in_stall rises while the register holds more than what the output takes
// this cycle. rst (synchronous) returns the decoder to normal mode, empties
// the result register and clears both configuration bits. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_decoder_core
  import esd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // input requests
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] ch,
  // decoded bytes
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            last,
  // configuration writes
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [0:0] cfg_data
);

  `include "escape_sequence_decoder_core_assert.svh"

  // configuration
  logic interpret_escapes;
  logic suppress_newline;

  // decoder state
  mode_t      mode;
  mode_t      mode_next;
  logic [8:0] escape_value;
  logic [8:0] escape_value_next;
  logic [1:0] digit_count;
  logic [1:0] digit_count_next;

  // result register: slot 0 is presented, slot 1 waits behind it
  logic [1:0] cnt;
  logic [7:0] slot1_byte;
  logic       slot0_last;

  logic       in_fire;
  logic       out_fire;
  emit_t      res;
  logic       pend_valid;
  logic [7:0] pend_byte;
  logic       plain_starts_escape;
  logic [4:0] hex;

  assign cfg_ready = 1'b1;
  assign out_valid = (cnt != 2'd0);
  assign last      = slot0_last;
  assign out_fire  = out_valid && !out_stall;
  // take a request once the result register drains this cycle
  assign in_stall  = !((cnt == 2'd0) || ((cnt == 2'd1) && !out_stall));
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      interpret_escapes <= 1'b0;
      suppress_newline  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INTERPRET: interpret_escapes <= cfg_data[0];
        CFG_SUPPRESS:  suppress_newline  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pending escape as it would be flushed by a boundary or the end
  assign pend_valid = (mode == MODE_BSLASH) || (mode == MODE_OCTAL) || (mode == MODE_HEX);
  assign pend_byte  = (mode == MODE_BSLASH) ? CHR_BSLASH : escape_value[7:0];
  // a backslash seen with no escape pending
  assign plain_starts_escape = interpret_escapes && (ch == CHR_BSLASH);
  assign hex = hex_digit(ch);

  always_comb begin
    res               = '0;
    mode_next         = mode;
    escape_value_next = escape_value;
    digit_count_next  = digit_count;
    unique case (cmd)
      CMD_DATA: begin
        unique case (mode)
          MODE_NORMAL: begin
            if (plain_starts_escape) begin
              mode_next = MODE_BSLASH;
            end else begin
              res = emit_push(res, ch);
            end
          end
          MODE_BSLASH: begin
            mode_next = MODE_NORMAL;
            case (ch)
              "a":        res = emit_push(res, 8'h07);
              "b":        res = emit_push(res, 8'h08);
              "e":        res = emit_push(res, CHR_ESC);
              "f":        res = emit_push(res, 8'h0C);
              "n":        res = emit_push(res, CHR_NEWLINE);
              "r":        res = emit_push(res, 8'h0D);
              "t":        res = emit_push(res, 8'h09);
              "v":        res = emit_push(res, 8'h0B);
              CHR_BSLASH: res = emit_push(res, CHR_BSLASH);
              "c":        mode_next = MODE_STOPPED;
              "0": begin
                mode_next         = MODE_OCTAL;
                escape_value_next = 9'd0;
                digit_count_next  = 2'd0;
              end
              "x": begin
                mode_next         = MODE_HEX;
                escape_value_next = 9'd0;
                digit_count_next  = 2'd0;
              end
              default: begin
                // unknown escape: keep the backslash and the character
                res = emit_push(res, CHR_BSLASH);
                res = emit_push(res, ch);
              end
            endcase
          end
          MODE_OCTAL: begin
            if (ch >= "0" && ch <= "7" && digit_count < OCT_DIGITS) begin
              if (digit_count == OCT_DIGITS - 2'd1) begin
                // third digit: emit the low byte at once
                res               = emit_push(res, {escape_value[4:0], ch[2:0]});
                mode_next         = MODE_NORMAL;
                escape_value_next = 9'd0;
                digit_count_next  = 2'd0;
              end else begin
                escape_value_next = {escape_value[5:0], ch[2:0]};
                digit_count_next  = digit_count + 2'd1;
              end
            end else begin
              // end of digits: emit the value, then treat the byte as plain
              res               = emit_push(res, escape_value[7:0]);
              escape_value_next = 9'd0;
              digit_count_next  = 2'd0;
              if (plain_starts_escape) begin
                mode_next = MODE_BSLASH;
              end else begin
                mode_next = MODE_NORMAL;
                res       = emit_push(res, ch);
              end
            end
          end
          MODE_HEX: begin
            if (hex[4] && digit_count < HEX_DIGITS) begin
              if (digit_count == HEX_DIGITS - 2'd1) begin
                res               = emit_push(res, {escape_value[3:0], hex[3:0]});
                mode_next         = MODE_NORMAL;
                escape_value_next = 9'd0;
                digit_count_next  = 2'd0;
              end else begin
                escape_value_next = {escape_value[4:0], hex[3:0]};
                digit_count_next  = digit_count + 2'd1;
              end
            end else begin
              res               = emit_push(res, escape_value[7:0]);
              escape_value_next = 9'd0;
              digit_count_next  = 2'd0;
              if (plain_starts_escape) begin
                mode_next = MODE_BSLASH;
              end else begin
                mode_next = MODE_NORMAL;
                res       = emit_push(res, ch);
              end
            end
          end
          MODE_STOPPED: ;
          default: ;
        endcase
      end
      CMD_BOUNDARY: begin
        // unless stopped, flush any pending escape, then separate arguments with a space
        if (mode != MODE_STOPPED) begin
          if (pend_valid) begin
            res = emit_push(res, pend_byte);
          end
          res               = emit_push(res, CHR_SPACE);
          mode_next         = MODE_NORMAL;
          escape_value_next = 9'd0;
          digit_count_next  = 2'd0;
        end
      end
      CMD_END: begin
        // a stop swallows the newline too; either way return to normal
        if (mode != MODE_STOPPED) begin
          if (pend_valid) begin
            res = emit_push(res, pend_byte);
          end
          if (!suppress_newline) begin
            res = emit_push(res, CHR_NEWLINE);
          end
        end
        mode_next         = MODE_NORMAL;
        escape_value_next = 9'd0;
        digit_count_next  = 2'd0;
      end
      default: ;
    endcase
  end

  // decoder state advances only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NORMAL;
      escape_value <= 9'd0;
      digit_count  <= 2'd0;
    end else if (in_fire) begin
      mode         <= mode_next;
      escape_value <= escape_value_next;
      digit_count  <= digit_count_next;
    end
  end

  // result register: load on accept, else drain toward slot 0
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (in_fire) begin
      cnt <= res.n;
    end else if (out_fire) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_byte   <= res.b0;
      slot0_last <= (res.n == 2'd1);
      slot1_byte <= res.b1;
    end else if (out_fire && (cnt == 2'd2)) begin
      out_byte   <= slot1_byte;
      slot0_last <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `ESD_ASSERT_ALWAYS(a_cnt_range, cnt != 2'd3)
  `ESD_ASSERT_ALWAYS(a_last_marks_final, !out_valid || (last == (cnt == 2'd1)))
  `ESD_ASSERT_NEXT(a_stopped_silent,
                   in_fire && (mode == MODE_STOPPED) && (cmd != CMD_END), cnt == 2'd0)
  `ESD_ASSERT_NEXT(a_end_returns_normal,
                   in_fire && (cmd == CMD_END), mode == MODE_NORMAL && digit_count == 2'd0)

endmodule

`default_nettype wire
